// File: sv/led_matrix_scan_framebuffer_core_macros.svh
// Assertion macros shared by the LED matrix frame store RTL.
// Included by modules that check their own control logic; needs nothing else.
`ifndef LED_MATRIX_SCAN_FRAMEBUFFER_CORE_MACROS_SVH
`define LED_MATRIX_SCAN_FRAMEBUFFER_CORE_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define LMSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lmsf_pkg.sv
// Shared types, constants and helpers for the LED matrix frame store.
// Used by every module of the block but lmsf_ram; depends on nothing.
`default_nettype none

package lmsf_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROW_ADDR_W  = 3;
  localparam int IDX_W       = 8;  // byte index within one frame
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_FILL = 2'd1,
    OP_SWAP = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e              kind;
    logic [IDX_W-1:0] idx;      // draw: byte offset of the plane-0 byte in the frame
    logic [2:0]       bit_sel;  // draw: column bit within the byte
    logic [1:0]       color;    // plane 1, plane 0
    logic             wr_hi;    // draw: plane-1 byte lies inside the row
    logic             copy;     // swap: copy new front into new back
  } cmd_t;

  // One streamed byte waiting in the output buffer.
  typedef struct packed {
    logic [BYTE_W-1:0]     row_byte;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  last_byte;
  } out_item_t;

  function automatic logic [BYTE_W-1:0] set_plane_bit(input logic [BYTE_W-1:0] b,
                                                      input logic [2:0] sel,
                                                      input logic v);
    logic [BYTE_W-1:0] m;
    m = BYTE_W'(1) << sel;
    set_plane_bit = v ? (b | m) : (b & ~m);
  endfunction

endpackage

`default_nettype wire

// File: sv/lmsf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
`default_nettype none

module lmsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/lmsf_front.sv
// Front end: accepts input words, classifies them, drops no-op items.
// Depends on lmsf_pkg; feeds lmsf_cmd_queue.
`default_nettype none

module lmsf_front #(
  parameter int PANEL_WIDTH   = 80,
  parameter int BYTES_PER_ROW = 20,
  parameter int VISIBLE_ROWS  = 8
) (
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [15:0]  in_data_i,
  input  wire logic [1:0]   in_kind_i,
  input  wire logic         db_i,
  input  wire logic         q_full_i,
  input  wire logic         clearing_i,
  output logic              push_o,
  output lmsf_pkg::cmd_t    cmd_o
);
  import lmsf_pkg::*;

  localparam logic [7:0] PW8  = 8'(PANEL_WIDTH);
  localparam logic [4:0] VR5  = 5'(VISIBLE_ROWS);
  localparam logic [5:0] BPR6 = 6'(BYTES_PER_ROW);

  op_e        op;
  logic [6:0] px;
  logic [3:0] py;
  logic [1:0] color;
  logic       cp;
  logic [4:0] off;
  logic       in_range;
  logic       wr_lo;
  logic       wr_hi;
  logic       keep;
  logic [7:0] row_base;

  assign op    = op_e'(in_kind_i);
  assign px    = in_data_i[6:0];
  assign py    = in_data_i[10:7];
  assign color = in_data_i[12:11];
  assign cp    = in_data_i[13];

  // Each group of eight columns owns a plane-0 byte and the plane-1 byte after it.
  assign off      = {px[6:3], 1'b0};
  assign in_range = ({1'b0, px} < PW8) && ({1'b0, py} < VR5);
  assign wr_lo    = {1'b0, off} < BPR6;
  assign wr_hi    = ({1'b0, off} + 6'd1) < BPR6;
  assign row_base = 8'(11'(py[2:0]) * 11'(BYTES_PER_ROW));

  always_comb begin
    case (op)
      OP_DRAW: keep = in_range && wr_lo;
      OP_SWAP: keep = db_i;
      OP_FILL: keep = 1'b1;
      OP_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o    = !q_full_i && !clearing_i;
  assign push_o        = in_valid_i && in_ready_o && keep;
  assign cmd_o.kind    = op;
  assign cmd_o.idx     = row_base + 8'(off);
  assign cmd_o.bit_sel = px[2:0];
  assign cmd_o.color   = color;
  assign cmd_o.wr_hi   = wr_hi;
  assign cmd_o.copy    = cp;

endmodule

`default_nettype wire

// File: sv/lmsf_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on lmsf_pkg and the assertion macro header.
`default_nettype none

`include "led_matrix_scan_framebuffer_core_macros.svh"

module lmsf_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lmsf_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output lmsf_pkg::cmd_t      cmd_o
);
  import lmsf_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d;
  logic [QPTR_W-1:0] rp_q, rp_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  `LMSF_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o),
               "command pushed into full queue")
  `LMSF_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && !valid_o),
               "command popped from empty queue")
  `LMSF_ASSERT(a_cnt_in_range, clk_i, rst_ni, cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH),
               "queue count beyond depth")

endmodule

`default_nettype wire

// File: sv/lmsf_back.sv
// Back end: frame store sequencer for draw, fill, swap, copy and row streaming.
// Depends on lmsf_pkg, lmsf_ram and the assertion macro header.
`default_nettype none

`include "led_matrix_scan_framebuffer_core_macros.svh"

module lmsf_back #(
  parameter int BYTES_PER_ROW = 20,
  parameter int SCAN_ROWS     = 10,
  parameter int VISIBLE_ROWS  = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           db_i,
  input  wire logic           cmd_valid_i,
  input  wire lmsf_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lmsf_pkg::out_item_t out_item_o
);
  import lmsf_pkg::*;

  localparam int FRAME = VISIBLE_ROWS * BYTES_PER_ROW;
  localparam int STORE = 2 * FRAME;
  localparam int AW    = $clog2(STORE);
  localparam int CNTW  = $clog2(STORE + 1);
  localparam int SW    = $clog2(SCAN_ROWS);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_DRAW_W0 = 7'b0000100,
    ST_DRAW_W1 = 7'b0001000,
    ST_FILL    = 7'b0010000,
    ST_COPY    = 7'b0100000,
    ST_STREAM  = 7'b1000000
  } state_e;

  state_e            st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]     base_q, base_d;
  logic [SW-1:0]     scan_q, scan_d;
  logic              back_sel_q, back_sel_d;
  logic              swap_pend_q, swap_pend_d;
  logic              copy_pend_q, copy_pend_d;
  logic              rdv_q, rdv_d;
  logic              rd_last_q, rd_last_d;
  logic [ROW_ADDR_W-1:0] rd_row_q, rd_row_d;

  out_item_t         ob_q [2];
  logic              ob_wp_q, ob_rp_q;
  logic [1:0]        ob_cnt_q;
  logic              ob_pop;
  logic [2:0]        ob_occ;
  logic              ob_room;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] wdata, rdata;

  logic [AW-1:0]     back_base, front_base, new_front_base;
  logic [SW-1:0]     scan_next;
  logic              new_back_sel;
  logic [AW-1:0]     cmd_idx;

  lmsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign back_base      = (db_i && back_sel_q) ? AW'(FRAME) : '0;
  assign front_base     = (db_i && !back_sel_q) ? AW'(FRAME) : '0;
  assign new_back_sel   = back_sel_q ^ swap_pend_q;
  assign new_front_base = (db_i && !new_back_sel) ? AW'(FRAME) : '0;
  assign scan_next      = (scan_q == SW'(SCAN_ROWS - 1)) ? '0 : scan_q + 1'b1;
  assign cmd_idx        = AW'(cmd_q.idx);

  assign clearing_o  = st_q == ST_CLEAR;
  assign out_valid_o = ob_cnt_q != 2'd0;
  assign out_item_o  = ob_q[ob_rp_q];
  assign ob_pop      = out_valid_o && out_ready_i;
  // Issue a stream read only if its byte is sure to find a slot next cycle.
  assign ob_occ      = {1'b0, ob_cnt_q} + 3'(rdv_q) - 3'(ob_pop);
  assign ob_room     = ob_occ < 3'd2;

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    scan_d      = scan_q;
    back_sel_d  = back_sel_q;
    swap_pend_d = swap_pend_q;
    copy_pend_d = copy_pend_q;
    rdv_d       = 1'b0;
    rd_last_d   = rd_last_q;
    rd_row_d    = rd_row_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    wdata       = '0;

    case (st_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        if (cnt_q == CNTW'(STORE - 1)) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cnt_d     = '0;
          case (cmd_i.kind)
            OP_DRAW: begin
              re    = 1'b1;
              raddr = back_base + AW'(cmd_i.idx);
              st_d  = ST_DRAW_W0;
            end
            OP_FILL: begin
              st_d = ST_FILL;
            end
            OP_SWAP: begin
              swap_pend_d = 1'b1;
              copy_pend_d = cmd_i.copy;
            end
            OP_TICK: begin
              scan_d      = scan_next;
              back_sel_d  = new_back_sel;
              swap_pend_d = 1'b0;
              copy_pend_d = 1'b0;
              base_d      = new_front_base + AW'(16'(scan_next) * 16'(BYTES_PER_ROW));
              if (swap_pend_q && copy_pend_q && db_i) begin
                st_d = ST_COPY;
              end else if (32'(scan_next) < VISIBLE_ROWS) begin
                st_d = ST_STREAM;
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end

      ST_DRAW_W0: begin
        we    = 1'b1;
        waddr = back_base + cmd_idx;
        wdata = set_plane_bit(rdata, cmd_q.bit_sel, cmd_q.color[0]);
        if (cmd_q.wr_hi) begin
          re    = 1'b1;
          raddr = back_base + cmd_idx + 1'b1;
          st_d  = ST_DRAW_W1;
        end else begin
          st_d = ST_IDLE;
        end
      end

      ST_DRAW_W1: begin
        we    = 1'b1;
        waddr = back_base + cmd_idx + 1'b1;
        wdata = set_plane_bit(rdata, cmd_q.bit_sel, cmd_q.color[1]);
        st_d  = ST_IDLE;
      end

      ST_FILL: begin
        we    = 1'b1;
        waddr = back_base + cnt_q[AW-1:0];
        wdata = cnt_q[0] ? {BYTE_W{cmd_q.color[1]}} : {BYTE_W{cmd_q.color[0]}};
        if (cnt_q == CNTW'(FRAME - 1)) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_COPY: begin
        // Read byte n of the front while writing byte n-1 into the back.
        if (cnt_q != CNTW'(FRAME)) begin
          re    = 1'b1;
          raddr = front_base + cnt_q[AW-1:0];
        end
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = back_base + cnt_q[AW-1:0] - 1'b1;
          wdata = rdata;
        end
        if (cnt_q == CNTW'(FRAME)) begin
          cnt_d = '0;
          st_d  = (32'(scan_q) < VISIBLE_ROWS) ? ST_STREAM : ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_STREAM: begin
        if (ob_room) begin
          re        = 1'b1;
          raddr     = base_q + cnt_q[AW-1:0];
          rdv_d     = 1'b1;
          rd_last_d = cnt_q == CNTW'(BYTES_PER_ROW - 1);
          rd_row_d  = ROW_ADDR_W'(scan_q);
          if (cnt_q == CNTW'(BYTES_PER_ROW - 1)) begin
            cnt_d = '0;
            st_d  = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      cnt_q       <= '0;
      scan_q      <= '0;
      back_sel_q  <= 1'b0;
      swap_pend_q <= 1'b0;
      copy_pend_q <= 1'b0;
      rdv_q       <= 1'b0;
      ob_wp_q     <= 1'b0;
      ob_rp_q     <= 1'b0;
      ob_cnt_q    <= 2'd0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      back_sel_q  <= back_sel_d;
      swap_pend_q <= swap_pend_d;
      copy_pend_q <= copy_pend_d;
      rdv_q       <= rdv_d;
      if (rdv_q) begin
        ob_wp_q <= ~ob_wp_q;
      end
      if (ob_pop) begin
        ob_rp_q <= ~ob_rp_q;
      end
      ob_cnt_q <= ob_cnt_q + 2'(rdv_q) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    base_q    <= base_d;
    rd_last_q <= rd_last_d;
    rd_row_q  <= rd_row_d;
    if (rdv_q) begin
      ob_q[ob_wp_q] <= '{row_byte: rdata, row_address: rd_row_q, last_byte: rd_last_q};
    end
  end

  `LMSF_ASSERT(a_ob_no_overflow, clk_i, rst_ni,
               !(rdv_q && ob_cnt_q == 2'd2 && !ob_pop),
               "stream byte arrived with output buffer full")
  `LMSF_ASSERT(a_no_pop_in_clear, clk_i, rst_ni, !(clearing_o && cmd_pop_o),
               "command taken during clearing pass")
  `LMSF_ASSERT_NEXT(a_tick_clears_swap, clk_i, rst_ni,
                    cmd_pop_o && cmd_i.kind == OP_TICK,
                    !swap_pend_q && !copy_pend_q, "tick left a swap pending")

endmodule

`default_nettype wire

// File: sv/led_matrix_scan_framebuffer_core.sv
// Top level of the double-buffered LED matrix frame store with row scanner.
// Depends on lmsf_pkg, lmsf_front, lmsf_cmd_queue, lmsf_back and lmsf_ram.
`default_nettype none

// Two-color LED matrix frame store. Each visible row holds BYTES_PER_ROW bytes:
// every group of eight columns owns a plane-0 byte followed by a plane-1 byte,
// column x on bit (x mod 8). Draw and fill words write the back frame; in
// double-buffered mode a swap word is latched and taken at the next refresh
// tick, optionally copying the new front frame into the new back frame.
// A refresh tick advances the scan row (wrapping at SCAN_ROWS) and, for a visible
// row, streams that row of the front frame out, tlast on its final byte.
// After reset a clearing pass zeroes all 2*VISIBLE_ROWS*BYTES_PER_ROW bytes of
// the store (320 at the defaults) with s_axis_tready low. A front end takes one
// input word per cycle, while the queue is not full, into a four-entry command
// queue; the back end then carries out swaps, draws (read-modify-write through
// the store's read and write ports), fills of VISIBLE_ROWS*BYTES_PER_ROW bytes
// and ticks, a tick with an optional frame copy before its row burst, one byte
// per cycle while m_axis_tready stays high.
module led_matrix_scan_framebuffer_core #(
  parameter int PANEL_WIDTH   = 80,
  parameter int BYTES_PER_ROW = 20,
  parameter int SCAN_ROWS     = 10,
  parameter int VISIBLE_ROWS  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: double_buffered
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // pixel_x[6:0], pixel_y[10:7],
                                          // color_bits[12:11], copy_after_swap[13]
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  // row burst words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // row_byte[7:0], row_address[10:8]
  output logic             m_axis_tlast   // last_byte
);
  import lmsf_pkg::*;

  logic      db_q;
  logic      push;
  cmd_t      front_cmd;
  logic      q_full;
  logic      q_valid;
  cmd_t      q_cmd;
  logic      q_pop;
  logic      clearing;
  out_item_t out_item;

  // Configuration register; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      db_q <= cfg_data_i;
    end
  end

  // Classify words and drop the ones that change nothing.
  lmsf_front #(
    .PANEL_WIDTH   (PANEL_WIDTH),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .VISIBLE_ROWS  (VISIBLE_ROWS)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .db_i       (db_q),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // Decouple input acceptance from the store sequencer.
  lmsf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Carry out commands against the frame store and stream rows.
  lmsf_back #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .SCAN_ROWS     (SCAN_ROWS),
    .VISIBLE_ROWS  (VISIBLE_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .db_i        (db_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {5'b0, out_item.row_address, out_item.row_byte};
  assign m_axis_tlast = out_item.last_byte;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for led_matrix_scan_framebuffer_core: drives draw, fill,
// swap and tick words and compares every streamed row byte with a local frame model.
// Depends on lmsf_pkg and the core RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmsf_pkg::*;

  localparam int PANEL_WIDTH   = 80;
  localparam int BYTES_PER_ROW = 20;
  localparam int SCAN_ROWS     = 10;
  localparam int VISIBLE_ROWS  = 8;
  localparam int FRAME_BYTES   = VISIBLE_ROWS * BYTES_PER_ROW;
  localparam int STORE_BYTES   = 2 * FRAME_BYTES;

  // Cycles to let queued non-streaming work finish (four fills plus a copy tick).
  localparam int SETTLE_CYCLES = 1200;
  // Cycles without any accepted word before the run is declared hung.
  localparam int QUIET_LIMIT   = 20000;
  // Length of the forced receiver hold-off.
  localparam int LONG_STALL    = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_data_i    = 1'b0;
  logic        cfg_ready_o;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  led_matrix_scan_framebuffer_core #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .BYTES_PER_ROW(BYTES_PER_ROW),
    .SCAN_ROWS    (SCAN_ROWS),
    .VISIBLE_ROWS (VISIBLE_ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Frame model: both frames, buffer select, pending swap state and scan position.
  logic [7:0]  frame_mem [STORE_BYTES];
  logic        dbl_buf   = 1'b1;
  logic        back_sel  = 1'b0;
  logic        swap_pend = 1'b0;
  logic        copy_pend = 1'b0;
  int          scan_row  = 0;

  // Row bytes still owed by the block, oldest first.
  out_item_t   row_bytes_due[$];
  int unsigned n_fail = 0;

  // Idle percentages for both sides, and the hold-off request toggle.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        stall_tog    = 1'b0;
  logic        stall_seen   = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned back_base();
    return dbl_buf ? FRAME_BYTES * int'(back_sel) : 0;
  endfunction

  function automatic int unsigned front_base();
    return (dbl_buf && !back_sel) ? FRAME_BYTES : 0;
  endfunction

  // Advance the frame model by one accepted input word and queue the row bytes
  // it owes.
  task automatic apply_word(op_e op, logic [6:0] x, logic [3:0] y, logic [1:0] c,
                            logic cp);
    int unsigned col;
    int unsigned ofs;
    int unsigned bb;
    int unsigned fb;
    int          i;
    out_item_t   w;
    bb = back_base();
    case (op)
      OP_DRAW: begin
        // Drop pixels outside the panel; the y bound is the visible row count.
        if (x < PANEL_WIDTH && y < VISIBLE_ROWS) begin
          col = 2 * x[6:3];
          ofs = bb + y * BYTES_PER_ROW + col;
          if (col < BYTES_PER_ROW)     frame_mem[ofs][x[2:0]] = c[0];
          if (col + 1 < BYTES_PER_ROW) frame_mem[ofs + 1][x[2:0]] = c[1];
        end
      end
      OP_FILL: begin
        for (i = 0; i < FRAME_BYTES; i++) frame_mem[bb + i] = {8{c[i & 1]}};
      end
      OP_SWAP: begin
        // Latch only when double-buffered; a repeat overrides the copy choice.
        if (dbl_buf) begin
          swap_pend = 1'b1;
          copy_pend = cp;
        end
      end
      OP_TICK: begin
        scan_row = (scan_row + 1 < SCAN_ROWS) ? scan_row + 1 : 0;
        if (swap_pend) begin
          back_sel = ~back_sel;
          bb = back_base();
          fb = front_base();
          if (copy_pend && fb != bb) begin
            for (i = 0; i < FRAME_BYTES; i++) frame_mem[bb + i] = frame_mem[fb + i];
          end
          swap_pend = 1'b0;
          copy_pend = 1'b0;
        end
        if (scan_row < VISIBLE_ROWS) begin
          fb = front_base() + scan_row * BYTES_PER_ROW;
          for (i = 0; i < BYTES_PER_ROW; i++) begin
            w.row_byte    = frame_mem[fb + i];
            w.row_address = 3'(scan_row);
            w.last_byte   = (i == BYTES_PER_ROW - 1);
            row_bytes_due.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one input word, after a random gap, and hold it until accepted.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(op_e op, logic [6:0] x, logic [3:0] y, logic [1:0] c,
                           logic cp);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cp, c, y, x};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_word(op, x, y, c, cp);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 7'($urandom), 4'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // Stop offering words, wait for every owed row byte, then let queued
  // draws, fills and copy ticks finish.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (row_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write double_buffered; it should be called only while the block is idle, which the task does not enforce.
  task automatic write_dbl_buf(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    dbl_buf = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Random word: mostly in-range draws and ticks, with some fills, swaps and
  // out-of-range draws as noise.
  task automatic send_random_word();
    int unsigned r;
    logic [6:0]  x;
    logic [3:0]  y;
    r = $urandom_range(99);
    if (r < 50) begin
      if ($urandom_range(99) < 85) begin
        x = 7'($urandom_range(PANEL_WIDTH - 1));
        y = 4'($urandom_range(VISIBLE_ROWS - 1));
      end else begin
        x = 7'($urandom_range(127));
        y = 4'($urandom_range(15));
      end
      send_word(OP_DRAW, x, y, 2'($urandom), 1'($urandom));
    end else if (r < 54) begin
      send_word(OP_FILL, 7'($urandom), 4'($urandom), 2'($urandom), 1'($urandom));
    end else if (r < 68) begin
      send_word(OP_SWAP, 7'($urandom), 4'($urandom), 2'($urandom), 1'($urandom));
    end else begin
      send_tick();
    end
  endtask

  // Field extremes, every operation, out-of-range draws, swap copy override and
  // a full wrap of the scan row through the hidden rows.
  task automatic test_directed();
    int i;
    send_tick();                                         // blank row 1
    send_word(OP_FILL, 7'd0, 4'd0, 2'b11, 1'b0);
    send_word(OP_DRAW, 7'd0, 4'd0, 2'b00, 1'b0);
    send_word(OP_DRAW, 7'd79, 4'd7, 2'b00, 1'b1);        // last pixel
    send_word(OP_DRAW, 7'd80, 4'd0, 2'b00, 1'b0);        // x just past the panel
    send_word(OP_DRAW, 7'd127, 4'd15, 2'b00, 1'b1);      // both out of range
    send_word(OP_DRAW, 7'd5, 4'd8, 2'b00, 1'b0);         // y past visible rows
    send_word(OP_DRAW, 7'd8, 4'd2, 2'b01, 1'b0);
    send_word(OP_DRAW, 7'd71, 4'd2, 2'b10, 1'b0);
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b0);
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b1);         // override: copy
    send_tick();
    send_word(OP_DRAW, 7'd33, 4'd3, 2'b00, 1'b0);        // lands in new back
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b1);
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b0);         // override: no copy
    send_word(OP_FILL, 7'd0, 4'd0, 2'b01, 1'b0);         // fill while swap pends
    for (i = 0; i < SCAN_ROWS; i++) send_tick();         // wrap through rows 8, 9
    drain_results();
  endtask

  // Single-buffered mode, including a swap latched before the register cleared.
  task automatic test_single_buffer();
    int i;
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b1);
    drain_results();
    write_dbl_buf(1'b0);
    send_tick();                                         // takes the stale swap
    send_word(OP_FILL, 7'd0, 4'd0, 2'b10, 1'b0);
    send_word(OP_DRAW, 7'd64, 4'd4, 2'b01, 1'b0);
    send_word(OP_SWAP, 7'd0, 4'd0, 2'b00, 1'b1);         // ignored
    for (i = 0; i < SCAN_ROWS; i++) send_tick();
    drain_results();
    write_dbl_buf(1'b1);
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct, int n);
    int i;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (i = 0; i < n; i++) send_random_word();
    drain_results();
  endtask

  // Hold the receiver off while ticks keep coming so the queue backs up, then
  // pause the sender until every row byte is out, then resume.
  task automatic test_backpressure();
    int i;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_tog <= ~stall_tog;
    for (i = 0; i < 12; i++) send_tick();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (row_bytes_due.size() != 0);
    for (i = 0; i < 12; i++) send_random_word();
    drain_results();
  endtask

  // Receiver: random ready, or a long hold-off when the test requests one.
  always @(posedge clk_i) begin
    if (stall_tog != stall_seen) begin
      stall_seen    <= stall_tog;
      stall_left    <= LONG_STALL;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare every accepted row byte with the oldest one owed.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (row_bytes_due.size() == 0) begin
        $error("unexpected row word: row_byte %0h row_address %0d last_byte %0b",
               m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast);
        n_fail++;
      end else begin
        want = row_bytes_due.pop_front();
        if (m_axis_tdata[7:0] !== want.row_byte) begin
          $error("row_byte: expected %0h, got %0h", want.row_byte, m_axis_tdata[7:0]);
          n_fail++;
        end
        if (m_axis_tdata[10:8] !== want.row_address) begin
          $error("row_address: expected %0d, got %0d", want.row_address,
                 m_axis_tdata[10:8]);
          n_fail++;
        end
        if (m_axis_tlast !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < STORE_BYTES; i++) frame_mem[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_dbl_buf(1'b1);

    src_idle_pct = 38;
    snk_idle_pct = 55;
    test_directed();
    test_single_buffer();
    test_random(38, 55, 80);
    write_dbl_buf(1'b0);
    test_random(55, 38, 80);
    write_dbl_buf(1'b1);
    test_random(0, 0, 80);
    test_backpressure();

    if (n_fail == 0 && row_bytes_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: led_matrix_scan_framebuffer_core.f
+incdir+sv
sv/lmsf_pkg.sv
sv/lmsf_ram.sv
sv/lmsf_front.sv
sv/lmsf_cmd_queue.sv
sv/lmsf_back.sv
sv/led_matrix_scan_framebuffer_core.sv
sim/tb.sv
